@@ hdl/line_pixel_stepper_core_macros.svh @@
// Assertion macros shared by the line pixel stepper checker.
// Depends on nothing; included by the checker file by bare name.
`ifndef LINE_PIXEL_STEPPER_CORE_MACROS_SVH
`define LINE_PIXEL_STEPPER_CORE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LPS_ASSERT_IMPLY(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("line pixel stepper check failed");

// Next-cycle implication, disabled while reset is high.
`define LPS_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("line pixel stepper check failed");

// Next-cycle implication that also holds across reset.
`define LPS_ASSERT_NEXT_ALWAYS(label, clk, pre, post) \
   label: assert property (@(posedge clk) (pre) |=> (post)) \
      else $error("line pixel stepper check failed");

`endif

@@ hdl/lps_pkg.sv @@
// Shared types and constants of the line pixel stepper.
// Depends on nothing; used by every module of the block.
`default_nettype none

package lps_pkg;

   // Width of the packed line color.
   localparam int COLOR_BITS = 24;

   // Action codes of an input item.
   localparam logic ACT_START = 1'b0;
   localparam logic ACT_STEP  = 1'b1;

   // Depth of the queue between the classifier and the stepper.
   // It must be a power of two so the pointers wrap on their own.
   localparam int QUEUE_DEPTH = 4;

   // Queue status seen by the front and the back.
   typedef struct packed {
      logic full;
      logic empty;
   } queue_status_type;

endpackage

`default_nettype wire

@@ hdl/lps_queue.sv @@
// Small register FIFO that decouples the classifier from the stepper.
// Depends on lps_pkg for the queue depth and the status struct.
`default_nettype none

module lps_queue #(
   parameter int WIDTH = 78
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push,
   input  wire logic [WIDTH-1:0] push_data,
   input  wire logic             pop,
   output logic      [WIDTH-1:0] pop_data,
   output lps_pkg::queue_status_type status
);

   localparam int DEPTH    = lps_pkg::QUEUE_DEPTH;
   localparam int PTR_BITS = $clog2(DEPTH);
   localparam int CNT_BITS = $clog2(DEPTH + 1);

   logic [WIDTH-1:0]    entry_ff [DEPTH];
   logic [PTR_BITS-1:0] wr_ptr_ff;
   logic [PTR_BITS-1:0] wr_ptr_in;
   logic [PTR_BITS-1:0] rd_ptr_ff;
   logic [PTR_BITS-1:0] rd_ptr_in;
   logic [CNT_BITS-1:0] count_ff;
   logic [CNT_BITS-1:0] count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PTR_BITS'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PTR_BITS'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + CNT_BITS'(1);
      end else if (pop && !push) begin
         count_in = count_ff - CNT_BITS'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data     = entry_ff[rd_ptr_ff];
   assign status.full  = (count_ff == CNT_BITS'(DEPTH));
   assign status.empty = (count_ff == '0);

endmodule

`default_nettype wire

@@ hdl/lps_front.sv @@
// Input classifier: takes items and works out the line setup of a start.
// Depends on lps_pkg for action codes, color width and queue status.
`default_nettype none

module lps_front #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_action,
   input  wire logic signed [COORD_BITS-1:0]    req_start_x,
   input  wire logic signed [COORD_BITS-1:0]    req_start_y,
   input  wire logic signed [COORD_BITS-1:0]    req_end_x,
   input  wire logic signed [COORD_BITS-1:0]    req_end_y,
   input  wire logic [lps_pkg::COLOR_BITS-1:0]  req_color_in,
   input  wire lps_pkg::queue_status_type       status,
   output logic                                 push,
   output logic                                 is_start,
   output logic signed [COORD_BITS-1:0]         start_x,
   output logic signed [COORD_BITS-1:0]         start_y,
   output logic                                 step_x_neg,
   output logic                                 step_y_neg,
   output logic                                 x_major,
   output logic [COORD_BITS:0]                  major_len,
   output logic [COORD_BITS:0]                  minor_len,
   output logic [lps_pkg::COLOR_BITS-1:0]       color
);

   logic signed [COORD_BITS:0] diff_x;
   logic signed [COORD_BITS:0] diff_y;
   logic        [COORD_BITS:0] len_x;
   logic        [COORD_BITS:0] len_y;

   assign req_stall = status.full;
   assign push      = req_valid && !status.full;

   always_comb begin
      diff_x     = {req_end_x[COORD_BITS-1], req_end_x}
                 - {req_start_x[COORD_BITS-1], req_start_x};
      diff_y     = {req_end_y[COORD_BITS-1], req_end_y}
                 - {req_start_y[COORD_BITS-1], req_start_y};
      len_x      = diff_x[COORD_BITS] ? -diff_x : diff_x;
      len_y      = diff_y[COORD_BITS] ? -diff_y : diff_y;
      // An axis steps negative unless the end lies strictly above the start.
      step_x_neg = diff_x[COORD_BITS] || (diff_x == '0);
      step_y_neg = diff_y[COORD_BITS] || (diff_y == '0);
      // Ties go to x as the major axis.
      x_major    = (len_x >= len_y);
      major_len  = x_major ? len_x : len_y;
      minor_len  = x_major ? len_y : len_x;
      is_start   = (req_action == lps_pkg::ACT_START);
      start_x    = req_start_x;
      start_y    = req_start_y;
      color      = req_color_in;
   end

endmodule

`default_nettype wire

@@ hdl/lps_back.sv @@
// Pixel stepper: holds the running line and registers one result per item.
// Depends on lps_pkg for the color width and the queue status struct.
`default_nettype none

module lps_back #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lps_pkg::queue_status_type       status,
   output logic                                 pop,
   input  wire logic                            is_start,
   input  wire logic signed [COORD_BITS-1:0]    start_x,
   input  wire logic signed [COORD_BITS-1:0]    start_y,
   input  wire logic                            step_x_neg,
   input  wire logic                            step_y_neg,
   input  wire logic                            x_major,
   input  wire logic [COORD_BITS:0]             major_len,
   input  wire logic [COORD_BITS:0]             minor_len,
   input  wire logic [lps_pkg::COLOR_BITS-1:0]  color,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid_res,
   output logic signed [COORD_BITS-1:0]         rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]         rsp_pixel_y,
   output logic [lps_pkg::COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                                 rsp_last
);

   localparam int ERR_BITS = COORD_BITS + 2;
   localparam int CB       = lps_pkg::COLOR_BITS;

   // Line state.
   logic signed [COORD_BITS-1:0] cur_x_ff, cur_x_in;
   logic signed [COORD_BITS-1:0] cur_y_ff, cur_y_in;
   logic                         neg_x_ff, neg_x_in;
   logic                         neg_y_ff, neg_y_in;
   logic                         x_major_ff, x_major_in;
   logic [COORD_BITS:0]          major_ff, major_in;
   logic [COORD_BITS:0]          minor_ff, minor_in;
   logic signed [ERR_BITS-1:0]   err_ff, err_in;
   logic [COORD_BITS:0]          remaining_ff, remaining_in;
   logic [CB-1:0]                color_ff, color_in;
   logic                         busy_ff, busy_in;

   // Result register.
   logic                         out_valid_ff, out_valid_in;
   logic                         out_res_ff, out_res_in;
   logic signed [COORD_BITS-1:0] out_x_ff, out_x_in;
   logic signed [COORD_BITS-1:0] out_y_ff, out_y_in;
   logic [CB-1:0]                out_color_ff, out_color_in;
   logic                         out_last_ff, out_last_in;

   logic                         take;
   logic                         minor_step;
   logic signed [ERR_BITS-1:0]   major_s;
   logic signed [ERR_BITS-1:0]   minor_s;
   logic signed [COORD_BITS-1:0] inc_x;
   logic signed [COORD_BITS-1:0] inc_y;
   logic signed [COORD_BITS-1:0] next_x;
   logic signed [COORD_BITS-1:0] next_y;
   logic [COORD_BITS:0]          rem_next;

   assign take = !status.empty && (!out_valid_ff || !rsp_stall);
   assign pop  = take;

   always_comb begin
      major_s    = $signed({1'b0, major_ff});
      minor_s    = $signed({1'b0, minor_ff});
      minor_step = !err_ff[ERR_BITS-1] && (err_ff != '0);
      // All ones is minus one, otherwise plus one.
      inc_x      = $signed({{(COORD_BITS-1){neg_x_ff}}, 1'b1});
      inc_y      = $signed({{(COORD_BITS-1){neg_y_ff}}, 1'b1});
      next_x     = (x_major_ff || minor_step) ? cur_x_ff + inc_x : cur_x_ff;
      next_y     = (!x_major_ff || minor_step) ? cur_y_ff + inc_y : cur_y_ff;
      rem_next   = remaining_ff - (COORD_BITS+1)'(1);

      cur_x_in     = cur_x_ff;
      cur_y_in     = cur_y_ff;
      neg_x_in     = neg_x_ff;
      neg_y_in     = neg_y_ff;
      x_major_in   = x_major_ff;
      major_in     = major_ff;
      minor_in     = minor_ff;
      err_in       = err_ff;
      remaining_in = remaining_ff;
      color_in     = color_ff;
      busy_in      = busy_ff;

      out_valid_in = out_valid_ff && rsp_stall;
      out_res_in   = out_res_ff;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;

      if (take) begin
         out_valid_in = 1'b1;
         if (is_start) begin
            cur_x_in     = start_x;
            cur_y_in     = start_y;
            neg_x_in     = step_x_neg;
            neg_y_in     = step_y_neg;
            x_major_in   = x_major;
            major_in     = major_len;
            minor_in     = minor_len;
            // The minor length never exceeds the major one, so the
            // initial error fits the error register.
            err_in       = ERR_BITS'($signed({1'b0, minor_len, 1'b0})
                                   - $signed({1'b0, major_len}));
            remaining_in = major_len;
            color_in     = color;
            busy_in      = (major_len != '0);
            out_res_in   = 1'b1;
            out_x_in     = start_x;
            out_y_in     = start_y;
            out_color_in = color;
            out_last_in  = (major_len == '0);
         end else if (!busy_ff) begin
            // A step with no line running gives an empty result.
            out_res_in   = 1'b0;
            out_x_in     = '0;
            out_y_in     = '0;
            out_color_in = '0;
            out_last_in  = 1'b0;
         end else begin
            err_in       = err_ff - (minor_step ? major_s : '0) + minor_s;
            cur_x_in     = next_x;
            cur_y_in     = next_y;
            remaining_in = rem_next;
            busy_in      = (rem_next != '0);
            out_res_in   = 1'b1;
            out_x_in     = next_x;
            out_y_in     = next_y;
            out_color_in = color_ff;
            out_last_in  = (rem_next == '0);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cur_x_ff     <= cur_x_in;
      cur_y_ff     <= cur_y_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      x_major_ff   <= x_major_in;
      major_ff     <= major_in;
      minor_ff     <= minor_in;
      err_ff       <= err_in;
      remaining_ff <= remaining_in;
      color_ff     <= color_in;
      out_res_ff   <= out_res_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   assign rsp_valid       = out_valid_ff;
   assign rsp_valid_res   = out_res_ff;
   assign rsp_pixel_x     = out_x_ff;
   assign rsp_pixel_y     = out_y_ff;
   assign rsp_pixel_color = out_color_ff;
   assign rsp_last        = out_last_ff;

endmodule

`default_nettype wire

@@ hdl/line_pixel_stepper_core.sv @@
// Top level of the line pixel stepper: classifier, queue and stepper.
// Depends on lps_pkg, lps_front, lps_queue and lps_back.
//
//   Channel   Direction   Handshake              Carries
//   req_      in          req_valid/req_stall    start or step item
//   rsp_      out         rsp_valid/rsp_stall    one pixel result per item
//
// The block takes one item per clock while req_stall is low, and returns one
// result per clock while rsp_stall is low and an item is queued. An accepted
// item passes the queue, then the stepper's result register, to reach rsp_.
// Reset is synchronous and active high; it empties the queue, drops the
// result register and leaves no line running.
// When rsp_stall holds the result, the queue still takes up to four items
// before req_stall rises.
`default_nettype none

module line_pixel_stepper_core #(
   parameter int COORD_BITS = 12
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire logic                            req_action,
   input  wire logic signed [COORD_BITS-1:0]    req_start_x,
   input  wire logic signed [COORD_BITS-1:0]    req_start_y,
   input  wire logic signed [COORD_BITS-1:0]    req_end_x,
   input  wire logic signed [COORD_BITS-1:0]    req_end_y,
   input  wire logic [lps_pkg::COLOR_BITS-1:0]  req_color_in,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output logic                                 rsp_valid_res,
   output logic signed [COORD_BITS-1:0]         rsp_pixel_x,
   output logic signed [COORD_BITS-1:0]         rsp_pixel_y,
   output logic [lps_pkg::COLOR_BITS-1:0]       rsp_pixel_color,
   output logic                                 rsp_last
);

   // One queue entry: action, start point, directions, major axis flag,
   // both lengths and the color.
   localparam int ENTRY_BITS = 1 + 2 * COORD_BITS + 3 + 2 * (COORD_BITS + 1)
                             + lps_pkg::COLOR_BITS;

   lps_pkg::queue_status_type status;

   logic                            push;
   logic                            pop;
   logic [ENTRY_BITS-1:0]           push_data;
   logic [ENTRY_BITS-1:0]           pop_data;

   // Classified item on its way into the queue.
   logic                            f_start;
   logic signed [COORD_BITS-1:0]    f_x;
   logic signed [COORD_BITS-1:0]    f_y;
   logic                            f_neg_x;
   logic                            f_neg_y;
   logic                            f_x_major;
   logic [COORD_BITS:0]             f_major;
   logic [COORD_BITS:0]             f_minor;
   logic [lps_pkg::COLOR_BITS-1:0]  f_color;

   // Head of the queue as the stepper sees it.
   logic                            b_start;
   logic signed [COORD_BITS-1:0]    b_x;
   logic signed [COORD_BITS-1:0]    b_y;
   logic                            b_neg_x;
   logic                            b_neg_y;
   logic                            b_x_major;
   logic [COORD_BITS:0]             b_major;
   logic [COORD_BITS:0]             b_minor;
   logic [lps_pkg::COLOR_BITS-1:0]  b_color;

   // The front does the subtract, absolute value and compare of a start, so
   // the stepper only has to load them and form the initial error term.
   lps_front #(
      .COORD_BITS (COORD_BITS)
   ) u_front (
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_action   (req_action),
      .req_start_x  (req_start_x),
      .req_start_y  (req_start_y),
      .req_end_x    (req_end_x),
      .req_end_y    (req_end_y),
      .req_color_in (req_color_in),
      .status       (status),
      .push         (push),
      .is_start     (f_start),
      .start_x      (f_x),
      .start_y      (f_y),
      .step_x_neg   (f_neg_x),
      .step_y_neg   (f_neg_y),
      .x_major      (f_x_major),
      .major_len    (f_major),
      .minor_len    (f_minor),
      .color        (f_color)
   );

   assign push_data = {f_start, f_x, f_y, f_neg_x, f_neg_y, f_x_major,
                       f_major, f_minor, f_color};

   lps_queue #(
      .WIDTH (ENTRY_BITS)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .status    (status)
   );

   assign {b_start, b_x, b_y, b_neg_x, b_neg_y, b_x_major,
           b_major, b_minor, b_color} = pop_data;

   // The stepper holds the running line and advances it one pixel per step
   // item; a start item replaces whatever line was running.
   lps_back #(
      .COORD_BITS (COORD_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .status          (status),
      .pop             (pop),
      .is_start        (b_start),
      .start_x         (b_x),
      .start_y         (b_y),
      .step_x_neg      (b_neg_x),
      .step_y_neg      (b_neg_y),
      .x_major         (b_x_major),
      .major_len       (b_major),
      .minor_len       (b_minor),
      .color           (b_color),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_valid_res   (rsp_valid_res),
      .rsp_pixel_x     (rsp_pixel_x),
      .rsp_pixel_y     (rsp_pixel_y),
      .rsp_pixel_color (rsp_pixel_color),
      .rsp_last        (rsp_last)
   );

endmodule

`default_nettype wire

@@ hdl/lps_checker.sv @@
// Port-level checks of the line pixel stepper, bound to its top level.
// Depends on lps_pkg and line_pixel_stepper_core_macros.svh.
`default_nettype none

`include "line_pixel_stepper_core_macros.svh"

module lps_checker #(
   parameter int COORD_BITS = 12
) (
   input wire logic                            clock,
   input wire logic                            reset,
   input wire logic                            rsp_valid,
   input wire logic                            rsp_stall,
   input wire logic                            rsp_valid_res,
   input wire logic signed [COORD_BITS-1:0]    rsp_pixel_x,
   input wire logic signed [COORD_BITS-1:0]    rsp_pixel_y,
   input wire logic [lps_pkg::COLOR_BITS-1:0]  rsp_pixel_color,
   input wire logic                            rsp_last
);

   // A held result stays offered.
   `LPS_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid)

   // A held result keeps its pixel.
   `LPS_ASSERT_NEXT(a_rsp_stable, clock, reset, rsp_valid && rsp_stall, $stable(rsp_pixel_x) && $stable(rsp_pixel_y) && $stable(rsp_pixel_color) && $stable(rsp_last))

   // An empty result carries zero fields and never marks a line end.
   `LPS_ASSERT_IMPLY(a_empty_zero, clock, reset, rsp_valid && !rsp_valid_res, rsp_pixel_x == '0 && rsp_pixel_y == '0 && rsp_pixel_color == '0 && !rsp_last)

   // Nothing is offered in the cycle after reset.
   `LPS_ASSERT_NEXT_ALWAYS(a_reset_quiet, clock, reset, !rsp_valid)

endmodule

bind line_pixel_stepper_core lps_checker #(
   .COORD_BITS (COORD_BITS)
) u_lps_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_valid_res   (rsp_valid_res),
   .rsp_pixel_x     (rsp_pixel_x),
   .rsp_pixel_y     (rsp_pixel_y),
   .rsp_pixel_color (rsp_pixel_color),
   .rsp_last        (rsp_last)
);

`default_nettype wire
